// ===== src/gffe_pkg.sv =====
// Package for the grid flood-fill engine: transaction structs, operation,
// register-index, neighbour and state codes, and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gffe_pkg;

   localparam int GFFE_MAX_SIDE   = 16;
   localparam int GFFE_NUM_COLORS = 4;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_FILL    = 2'd1,
      OP_RESTART = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_WRAP_ENABLE = 2'd2,
      CSR_MAX_MOVES   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      NB_RIGHT = 2'd0,
      NB_DOWN  = 2'd1,
      NB_LEFT  = 2'd2,
      NB_UP    = 2'd3
   } nb_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RDATA,
      ST_COPY,
      ST_FTC,
      ST_POP,
      ST_CELL,
      ST_NB,
      ST_LAST,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] col_x;
      logic [3:0] row_y;
      logic [3:0] paint_color;
   } req_type;

   typedef struct packed {
      logic [3:0] cell_color;
      logic [7:0] moves_used;
      logic       uniform;
      logic       bad_request;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/grid_flood_fill_engine_core.sv =====
// Grid flood-fill engine: colour grid, initial copy and work stack kept in
// synchronous memories, with a stack-driven 4-connected fill. Uses gffe_pkg.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  request  | start, busy, req_data                   | taken when start && !busy
//  result   | rsp_valid, rsp_data                     | one-cycle strobe, no back-pressure
//  config   | csr_we, csr_index, csr_wdata            | written when csr_we is high
//
// After reset a clearing pass over all MAX_SIDE*MAX_SIDE cells zeroes both grids; busy
// stays high meanwhile. Every transaction ends in a scan of the w*h cells in use
// (one memory read per cycle) to form the uniform flag. A restart first copies the
// initial grid back, then scans; a fill pops each recoloured cell off the stack and
// checks its four neighbours in turn through the single grid read port.
// The result strobe lasts one cycle; a new request may be taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module grid_flood_fill_engine_core #(
   parameter int MAX_SIDE   = gffe_pkg::GFFE_MAX_SIDE,
   parameter int NUM_COLORS = gffe_pkg::GFFE_NUM_COLORS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire gffe_pkg::req_type req_data,
   output      logic             rsp_valid,
   output      gffe_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_wdata
);

   import gffe_pkg::*;

   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int IW    = $clog2(CELLS);
   localparam int NW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(MAX_SIDE);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int EW    = (SW > 5) ? SW : 5;
   localparam int PW    = CW + SW;
   localparam int CLR_W = $clog2(NUM_COLORS);
   localparam int SKW   = 2 * CW;

   // configuration registers
   logic [4:0] wid_ff;
   logic [4:0] hgt_ff;
   logic       wrap_ff;
   logic [7:0] maxmv_ff;

   // control and datapath registers
   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [7:0]       move_cnt_ff, move_cnt_in;
   logic [3:0]       cell_ff, cell_in;
   logic             bad_ff, bad_in;
   logic             uni_ff, uni_in;
   logic [CLR_W-1:0] ref_ff, ref_in;
   logic [CLR_W-1:0] tc_ff, tc_in;
   logic [NW-1:0]    walk_ptr_ff, walk_ptr_in;
   logic             walk_vld_ff, walk_vld_in;
   logic             walk_first_ff, walk_first_in;
   logic [IW-1:0]    walk_addr_ff, walk_addr_in;
   logic [IW:0]      sp_ff, sp_in;
   logic [CW-1:0]    cur_x_ff, cur_x_in;
   logic [CW-1:0]    cur_y_ff, cur_y_in;
   nb_type           nb_k_ff, nb_k_in;
   logic             pend_vld_ff, pend_vld_in;
   logic             pend_fwd_ff, pend_fwd_in;
   logic [IW-1:0]    pend_addr_ff, pend_addr_in;
   logic [CW-1:0]    pend_x_ff, pend_x_in;
   logic [CW-1:0]    pend_y_ff, pend_y_in;

   // memories and their ports
   logic [CLR_W-1:0] grid_mem  [CELLS];
   logic [CLR_W-1:0] init_mem  [CELLS];
   logic [SKW-1:0]   stack_mem [CELLS];

   logic [CLR_W-1:0] grid_rd_ff;
   logic [CLR_W-1:0] init_rd_ff;
   logic [SKW-1:0]   stack_rd_ff;

   logic             grid_we;
   logic [IW-1:0]    grid_waddr;
   logic [CLR_W-1:0] grid_wdata;
   logic [IW-1:0]    grid_raddr;
   logic             init_we;
   logic [IW-1:0]    init_waddr;
   logic [CLR_W-1:0] init_wdata;
   logic [IW-1:0]    init_raddr;
   logic             stack_we;
   logic [IW-1:0]    stack_waddr;
   logic [SKW-1:0]   stack_wdata;
   logic [IW-1:0]    stack_raddr;

   // derived values
   logic [EW-1:0]    wid_ext;
   logic [EW-1:0]    hgt_ext;
   logic [SW-1:0]    w_side;
   logic [SW-1:0]    h_side;
   logic [NW-1:0]    n_cells;
   logic             coord_ok;
   logic             color_ok;
   logic [IW-1:0]    req_addr;
   logic [CLR_W-1:0] fc;
   logic             accept;
   logic             push;

   logic [SW-1:0]    cx_s;
   logic [SW-1:0]    cy_s;
   logic [SW-1:0]    nx_s;
   logic [SW-1:0]    ny_s;
   logic             nb_ok;
   logic [IW-1:0]    nb_addr;

   function automatic logic [IW-1:0] cell_addr(input logic [CW-1:0] y,
                                               input logic [CW-1:0] x,
                                               input logic [SW-1:0] w);
      logic [PW-1:0] prod;
      prod = PW'(y) * PW'(w);
      return IW'(prod + PW'(x));
   endfunction

   // clamp the side registers into 1..MAX_SIDE
   assign wid_ext = EW'(wid_ff);
   assign hgt_ext = EW'(hgt_ff);
   assign w_side  = (wid_ff == '0) ? SW'(1) :
                    (wid_ext > EW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(wid_ext);
   assign h_side  = (hgt_ff == '0) ? SW'(1) :
                    (hgt_ext > EW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(hgt_ext);
   assign n_cells = NW'(w_side) * NW'(h_side);

   assign coord_ok = (EW'(req_ff.col_x) < EW'(w_side)) && (EW'(req_ff.row_y) < EW'(h_side));
   assign color_ok = (5'(req_ff.paint_color) < 5'(NUM_COLORS));
   assign req_addr = cell_addr(CW'(req_ff.row_y), CW'(req_ff.col_x), w_side);
   assign fc       = CLR_W'(req_ff.paint_color);

   assign busy      = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = {cell_ff, move_cnt_ff, uni_ff, bad_ff};

   // a pending neighbour still holding the target colour gets painted and pushed
   assign push = (state_ff == ST_NB || state_ff == ST_LAST) && pend_vld_ff &&
                 !pend_fwd_ff && (grid_rd_ff == tc_ff);

   // neighbour of the current cell selected by nb_k_ff
   always_comb begin
      cx_s  = SW'(cur_x_ff);
      cy_s  = SW'(cur_y_ff);
      nx_s  = cx_s;
      ny_s  = cy_s;
      nb_ok = 1'b1;
      case (nb_k_ff)
         NB_RIGHT: begin
            nx_s = cx_s + SW'(1);
            if (wrap_ff) begin
               if (nx_s == w_side) nx_s = '0;
            end else begin
               nb_ok = (nx_s < w_side);
            end
         end
         NB_DOWN: begin
            ny_s = cy_s + SW'(1);
            if (wrap_ff) begin
               if (ny_s == h_side) ny_s = '0;
            end else begin
               nb_ok = (ny_s < h_side);
            end
         end
         NB_LEFT: begin
            if (cx_s == '0) begin
               nx_s  = w_side - SW'(1);
               nb_ok = wrap_ff;
            end else begin
               nx_s = cx_s - SW'(1);
            end
         end
         default: begin
            if (cy_s == '0) begin
               ny_s  = h_side - SW'(1);
               nb_ok = wrap_ff;
            end else begin
               ny_s = cy_s - SW'(1);
            end
         end
      endcase
      nb_addr = cell_addr(CW'(ny_s), CW'(nx_s), w_side);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, datapath and memory controls
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      move_cnt_in   = move_cnt_ff;
      cell_in       = cell_ff;
      bad_in        = bad_ff;
      uni_in        = uni_ff;
      ref_in        = ref_ff;
      tc_in         = tc_ff;
      walk_ptr_in   = walk_ptr_ff;
      walk_vld_in   = walk_vld_ff;
      walk_first_in = walk_first_ff;
      walk_addr_in  = walk_addr_ff;
      sp_in         = sp_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      nb_k_in       = nb_k_ff;
      pend_vld_in   = pend_vld_ff;
      pend_fwd_in   = pend_fwd_ff;
      pend_addr_in  = pend_addr_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;

      grid_we     = 1'b0;
      grid_waddr  = pend_addr_ff;
      grid_wdata  = fc;
      grid_raddr  = walk_ptr_ff[IW-1:0];
      init_we     = 1'b0;
      init_waddr  = req_addr;
      init_wdata  = fc;
      init_raddr  = walk_ptr_ff[IW-1:0];
      stack_we    = 1'b0;
      stack_waddr = sp_ff[IW-1:0];
      stack_wdata = {pend_y_ff, pend_x_ff};
      stack_raddr = IW'(sp_ff - (IW+1)'(1));

      if (push) begin
         grid_we  = 1'b1;
         stack_we = 1'b1;
         sp_in    = sp_ff + (IW+1)'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = walk_ptr_ff[IW-1:0];
            grid_wdata = '0;
            init_we    = 1'b1;
            init_waddr = walk_ptr_ff[IW-1:0];
            init_wdata = '0;
            if (walk_ptr_ff == NW'(CELLS - 1)) begin
               walk_ptr_in = '0;
               state_in    = ST_IDLE;
            end else begin
               walk_ptr_in = walk_ptr_ff + NW'(1);
            end
         end
         ST_IDLE, ST_RESP: begin
            state_in = ST_IDLE;
            if (accept) begin
               req_in      = req_data;
               walk_ptr_in = '0;
               walk_vld_in = 1'b0;
               uni_in      = 1'b1;
               bad_in      = 1'b0;
               cell_in     = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_SCAN;
            unique case (req_ff.op)
               OP_LOAD: begin
                  if (coord_ok && color_ok) begin
                     grid_we    = 1'b1;
                     grid_waddr = req_addr;
                     grid_wdata = fc;
                     init_we    = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               OP_FILL: begin
                  grid_raddr = '0;
                  if (!color_ok) begin
                     bad_in = 1'b1;
                  end else if (move_cnt_ff < maxmv_ff) begin
                     state_in = ST_FTC;
                  end
               end
               OP_RESTART: begin
                  move_cnt_in = '0;
                  state_in    = ST_COPY;
               end
               OP_READ: begin
                  grid_raddr = req_addr;
                  if (coord_ok) begin
                     state_in = ST_RDATA;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            endcase
         end
         ST_RDATA: begin
            cell_in  = 4'(grid_rd_ff);
            state_in = ST_SCAN;
         end
         ST_COPY: begin
            // write back the entry read in the previous cycle
            if (walk_vld_ff) begin
               grid_we    = 1'b1;
               grid_waddr = walk_addr_ff;
               grid_wdata = init_rd_ff;
            end
            if (walk_ptr_ff < n_cells) begin
               walk_vld_in  = 1'b1;
               walk_addr_in = walk_ptr_ff[IW-1:0];
               walk_ptr_in  = walk_ptr_ff + NW'(1);
            end else begin
               walk_vld_in = 1'b0;
               if (!walk_vld_ff) begin
                  walk_ptr_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_FTC: begin
            tc_in       = grid_rd_ff;
            move_cnt_in = move_cnt_ff + 8'd1;
            if (grid_rd_ff == fc) begin
               state_in = ST_SCAN;
            end else begin
               grid_we     = 1'b1;
               grid_waddr  = '0;
               stack_we    = 1'b1;
               stack_waddr = '0;
               stack_wdata = '0;
               sp_in       = (IW+1)'(1);
               state_in    = ST_POP;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_SCAN;
            end else begin
               sp_in    = sp_ff - (IW+1)'(1);
               state_in = ST_CELL;
            end
         end
         ST_CELL: begin
            {cur_y_in, cur_x_in} = stack_rd_ff;
            nb_k_in     = NB_RIGHT;
            pend_vld_in = 1'b0;
            pend_fwd_in = 1'b0;
            state_in    = ST_NB;
         end
         ST_NB: begin
            // issue this neighbour's read while the previous one is checked
            grid_raddr   = nb_addr;
            pend_vld_in  = nb_ok;
            pend_addr_in = nb_addr;
            pend_x_in    = CW'(nx_s);
            pend_y_in    = CW'(ny_s);
            pend_fwd_in  = push && (nb_addr == pend_addr_ff);
            if (nb_k_ff == NB_UP) begin
               state_in = ST_LAST;
            end else begin
               nb_k_in = nb_type'(nb_k_ff + 2'd1);
            end
         end
         ST_LAST: begin
            pend_vld_in = 1'b0;
            state_in    = ST_POP;
         end
         ST_SCAN: begin
            if (walk_vld_ff) begin
               if (walk_first_ff) begin
                  ref_in = grid_rd_ff;
               end else if (grid_rd_ff != ref_ff) begin
                  uni_in = 1'b0;
               end
            end
            if (walk_ptr_ff < n_cells) begin
               walk_vld_in   = 1'b1;
               walk_first_in = (walk_ptr_ff == '0);
               walk_ptr_in   = walk_ptr_ff + NW'(1);
            end else begin
               walk_vld_in = 1'b0;
               if (!walk_vld_ff) state_in = ST_RESP;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         move_cnt_ff <= '0;
         walk_ptr_ff <= '0;
         walk_vld_ff <= 1'b0;
         sp_ff       <= '0;
         pend_vld_ff <= 1'b0;
         pend_fwd_ff <= 1'b0;
      end else begin
         move_cnt_ff <= move_cnt_in;
         walk_ptr_ff <= walk_ptr_in;
         walk_vld_ff <= walk_vld_in;
         sp_ff       <= sp_in;
         pend_vld_ff <= pend_vld_in;
         pend_fwd_ff <= pend_fwd_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cell_ff       <= cell_in;
      bad_ff        <= bad_in;
      uni_ff        <= uni_in;
      ref_ff        <= ref_in;
      tc_ff         <= tc_in;
      walk_first_ff <= walk_first_in;
      walk_addr_ff  <= walk_addr_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      nb_k_ff       <= nb_k_in;
      pend_addr_ff  <= pend_addr_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff   <= 5'd12;
         hgt_ff   <= 5'd12;
         wrap_ff  <= 1'b0;
         maxmv_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  wid_ff   <= csr_wdata[4:0];
            CSR_GRID_HEIGHT: hgt_ff   <= csr_wdata[4:0];
            CSR_WRAP_ENABLE: wrap_ff  <= csr_wdata[0];
            CSR_MAX_MOVES:   maxmv_ff <= csr_wdata;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      grid_rd_ff <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (init_we) init_mem[init_waddr] <= init_wdata;
      init_rd_ff <= init_mem[init_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // assertions
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (IW+1)'(CELLS))
      else $error("work stack pointer past its depth");

   a_moves_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && move_cnt_ff != $past(move_cnt_ff)) |->
      ($past(state_ff) == ST_FTC || $past(state_ff) == ST_EXEC))
      else $error("move counter changed outside a fill or restart");

   a_fwd_in_fill: assert property (@(posedge clock) disable iff (reset)
      pend_fwd_ff |-> (state_ff == ST_NB || state_ff == ST_LAST))
      else $error("neighbour forwarding flag set outside the neighbour walk");

endmodule

`default_nettype wire

// ===== sim/grid_flood_fill_engine_core_tb.sv =====
// Self-checking testbench for grid_flood_fill_engine_core: a scoreboard class that tracks the
// colour grids and move counter predicts every result, and directed then random transactions
// drive the block. Depends on gffe_pkg and the core.
`timescale 1ns / 1ps

module grid_flood_fill_engine_core_tb;
   import gffe_pkg::*;

   localparam int CLOCK_HIGH_NS = 6;
   localparam int CLOCK_LOW_NS  = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int REPORT_CAP    = 200;
   localparam int CELL_COUNT    = GFFE_MAX_SIDE * GFFE_MAX_SIDE;

   class colour_grid_scoreboard;
      logic [3:0] grid_cells [CELL_COUNT];
      logic [3:0] start_cells [CELL_COUNT];
      logic [7:0] move_total;
      logic [4:0] width_reg;
      logic [4:0] height_reg;
      logic       wrap_reg;
      logic [7:0] move_limit;
      rsp_type    awaited_results [$];
      int         fail_count;

      function new();
         foreach (grid_cells[i]) begin
            grid_cells[i]  = '0;
            start_cells[i] = '0;
         end
         move_total = '0;
         width_reg  = 5'd12;
         height_reg = 5'd12;
         wrap_reg   = 1'b0;
         move_limit = 8'd1;
         fail_count = 0;
      endfunction

      function int clamp_side(logic [4:0] v);
         if (v == 0) return 1;
         if (v > GFFE_MAX_SIDE) return GFFE_MAX_SIDE;
         return int'(v);
      endfunction

      function int cols();
         return clamp_side(width_reg);
      endfunction

      function int rows();
         return clamp_side(height_reg);
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_GRID_WIDTH:  width_reg  = value[4:0];
            CSR_GRID_HEIGHT: height_reg = value[4:0];
            CSR_WRAP_ENABLE: wrap_reg   = value[0];
            CSR_MAX_MOVES:   move_limit = value;
         endcase
      endfunction

      // Recolour the 4-connected region holding cell (0,0).
      function void recolour_region(int w, int h, logic [3:0] colour);
         logic [3:0] target;
         int         pending [$];
         int         idx, x, y, nb, k;
         bit         has_nb;
         target = grid_cells[0];
         if (target == colour) return;
         grid_cells[0] = colour;
         pending.push_back(0);
         while (pending.size() > 0) begin
            idx = pending.pop_back();
            x = idx % w;
            y = idx / w;
            for (k = 0; k < 4; k++) begin
               has_nb = 1'b1;
               nb = 0;
               case (nb_type'(k))
                  NB_RIGHT: begin
                     if (x + 1 < w) nb = idx + 1;
                     else if (wrap_reg) nb = y * w;
                     else has_nb = 1'b0;
                  end
                  NB_DOWN: begin
                     if (y + 1 < h) nb = idx + w;
                     else if (wrap_reg) nb = x;
                     else has_nb = 1'b0;
                  end
                  NB_LEFT: begin
                     if (x > 0) nb = idx - 1;
                     else if (wrap_reg) nb = y * w + w - 1;
                     else has_nb = 1'b0;
                  end
                  NB_UP: begin
                     if (y > 0) nb = idx - w;
                     else if (wrap_reg) nb = (h - 1) * w + x;
                     else has_nb = 1'b0;
                  end
               endcase
               if (has_nb && grid_cells[nb] == target) begin
                  grid_cells[nb] = colour;
                  pending.push_back(nb);
               end
            end
         end
      endfunction

      // Apply one accepted transaction and queue the result it must produce.
      function void note_request(req_type r);
         rsp_type want;
         int      w, h, i;
         bit      coord_ok, colour_ok;
         w = cols();
         h = rows();
         coord_ok  = (int'(r.col_x) < w) && (int'(r.row_y) < h);
         colour_ok = int'(r.paint_color) < GFFE_NUM_COLORS;
         want = '0;
         case (r.op)
            OP_LOAD: begin
               if (coord_ok && colour_ok) begin
                  grid_cells[int'(r.row_y) * w + int'(r.col_x)]  = r.paint_color;
                  start_cells[int'(r.row_y) * w + int'(r.col_x)] = r.paint_color;
               end else begin
                  want.bad_request = 1'b1;
               end
            end
            OP_FILL: begin
               if (!colour_ok) begin
                  want.bad_request = 1'b1;
               end else if (move_total < move_limit) begin
                  recolour_region(w, h, r.paint_color);
                  move_total = move_total + 8'd1;
               end
            end
            OP_RESTART: begin
               for (i = 0; i < w * h; i++) grid_cells[i] = start_cells[i];
               move_total = '0;
            end
            OP_READ: begin
               if (coord_ok) want.cell_color = grid_cells[int'(r.row_y) * w + int'(r.col_x)];
               else want.bad_request = 1'b1;
            end
         endcase
         want.moves_used = move_total;
         want.uniform = 1'b1;
         for (i = 0; i < w * h; i++)
            if (grid_cells[i] != grid_cells[0]) want.uniform = 1'b0;
         awaited_results.push_back(want);
      endfunction

      task report_mismatch(string what, int got_val, int want_val);
         if (fail_count < REPORT_CAP)
            $display("%0t: result mismatch on %s: got %0d, expected %0d",
                     $realtime, what, got_val, want_val);
         fail_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch("unsolicited result", int'(got), 0);
            return;
         end
         want = awaited_results.pop_front();
         if (got.cell_color !== want.cell_color)
            report_mismatch("cell_color", got.cell_color, want.cell_color);
         if (got.moves_used !== want.moves_used)
            report_mismatch("moves_used", got.moves_used, want.moves_used);
         if (got.uniform !== want.uniform)
            report_mismatch("uniform", got.uniform, want.uniform);
         if (got.bad_request !== want.bad_request)
            report_mismatch("bad_request", got.bad_request, want.bad_request);
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   colour_grid_scoreboard board = new();
   int sender_idle_pct = 37;
   int quiet_cycles = 0;

   grid_flood_fill_engine_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("grid_flood_fill_engine_core_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold the transaction on the port, dropping start at random, until it is taken.
   task automatic send_request(input req_type r);
      req_data <= r;
      do begin
         start <= ($urandom_range(99) >= sender_idle_pct);
         @(posedge clock);
      end while (!(start && !busy));
      board.note_request(r);
   endtask

   task automatic issue(input op_type op, input int x, input int y, input int c);
      req_type r;
      r.op          = op;
      r.col_x       = 4'(x);
      r.row_y       = 4'(y);
      r.paint_color = 4'(c);
      send_request(r);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (board.awaited_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] width_val, input logic [7:0] height_val,
                                 input logic [7:0] wrap_val, input logic [7:0] limit_val);
      csr_index_type reg_order [4];
      logic [7:0]    reg_value [4];
      reg_order = '{CSR_GRID_WIDTH, CSR_GRID_HEIGHT, CSR_WRAP_ENABLE, CSR_MAX_MOVES};
      reg_value = '{width_val, height_val, wrap_val, limit_val};
      settle();
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_order[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
         board.write_reg(reg_order[i], reg_value[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly legal transactions inside the grid, with a tail of out-of-range noise.
   function automatic req_type random_item(input logic [3:0] bias_colour);
      req_type r;
      int      pick;
      pick          = $urandom_range(99);
      r.op          = OP_READ;
      r.col_x       = 4'($urandom_range(board.cols() - 1));
      r.row_y       = 4'($urandom_range(board.rows() - 1));
      r.paint_color = 4'($urandom_range(GFFE_NUM_COLORS - 1));
      if (pick < 35) begin
         r.op = OP_LOAD;
         if ($urandom_range(1)) r.paint_color = bias_colour;
      end else if (pick < 60) begin
         r.op = OP_FILL;
      end else if (pick < 85) begin
         r.paint_color = 4'($urandom);
      end else begin
         r.op          = (pick < 92) ? OP_RESTART : op_type'($urandom_range(3));
         r.col_x       = 4'($urandom);
         r.row_y       = 4'($urandom);
         r.paint_color = 4'($urandom);
      end
      return r;
   endfunction

   initial begin
      int         phase, n, item_total;
      logic [7:0] width_val, height_val, wrap_val, limit_val;
      logic [3:0] bias_colour;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Reset settings: 12 x 12, no wrap, one move allowed.
      issue(OP_READ, 0, 0, 0);
      issue(OP_READ, 15, 15, 15);
      issue(OP_LOAD, 11, 11, 3);
      issue(OP_LOAD, 0, 0, 4);
      issue(OP_LOAD, 12, 0, 1);
      issue(OP_LOAD, 0, 12, 2);
      issue(OP_FILL, 0, 0, 15);
      issue(OP_FILL, 0, 0, 0);
      issue(OP_FILL, 0, 0, 2);
      issue(OP_READ, 11, 11, 0);
      issue(OP_RESTART, 15, 15, 15);

      // Region reaches the far column and row only through the wrap.
      apply_settings(8'd3, 8'd3, 8'd1, 8'd255);
      issue(OP_LOAD, 0, 0, 1);
      issue(OP_LOAD, 2, 0, 1);
      issue(OP_LOAD, 0, 2, 1);
      issue(OP_FILL, 0, 0, 3);
      issue(OP_READ, 2, 0, 0);
      issue(OP_READ, 0, 2, 0);
      issue(OP_FILL, 0, 0, 3);

      // Width 0 acts as 1, height 31 as the maximum; no moves allowed.
      apply_settings(8'd0, 8'd31, 8'd0, 8'd0);
      issue(OP_FILL, 0, 0, 1);
      issue(OP_READ, 0, 15, 0);
      issue(OP_READ, 1, 0, 0);
      issue(OP_LOAD, 0, 15, 3);
      issue(OP_RESTART, 0, 0, 0);

      apply_settings(8'd16, 8'd16, 8'd0, 8'd255);
      issue(OP_FILL, 0, 0, 3);

      for (phase = 0; phase < 12; phase++) begin
         width_val  = 8'($urandom_range(1, 6));
         height_val = 8'($urandom_range(1, 6));
         if (phase == 3 || phase == 9) begin
            width_val  = 8'd16;
            height_val = 8'd16;
         end
         if (phase == 5) width_val = 8'd0;
         if (phase == 7) height_val = 8'($urandom_range(17, 31));
         if (phase == 10) width_val = {3'b111, 5'($urandom_range(1, 6))};
         wrap_val = {7'($urandom), 1'(phase & 1)};
         case (phase)
            1:       limit_val = 8'd0;
            2:       limit_val = 8'd1;
            4, 8:    limit_val = 8'd255;
            default: limit_val = 8'($urandom_range(2, 40));
         endcase
         apply_settings(width_val, height_val, wrap_val, limit_val);

         sender_idle_pct = (phase < 4) ? 37 : (phase < 8) ? 67 : 0;
         item_total = (phase == 3 || phase == 9) ? 24 : 52;
         bias_colour = 4'($urandom_range(GFFE_NUM_COLORS - 1));
         for (n = 0; n < item_total; n++) send_request(random_item(bias_colour));
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("grid_flood_fill_engine_core_tb: PASS");
      end else begin
         $display("grid_flood_fill_engine_core_tb: FAIL");
      end
      $finish;
   end

endmodule
